### rtl/framebuffer_pixel_blend_core_defines.svh
// ---------------------------------------------------------------------------
// Framebuffer pixel blend core: assertion macros
// Shared concurrent assertion forms for the blend core.
// ---------------------------------------------------------------------------
`ifndef FRAMEBUFFER_PIXEL_BLEND_CORE_DEFINES_SVH
`define FRAMEBUFFER_PIXEL_BLEND_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define FPB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define FPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fpb_pkg.sv
// ---------------------------------------------------------------------------
// Framebuffer pixel blend package
// Field widths, opcode and blend mode codes, default frame geometry.
// ---------------------------------------------------------------------------
`default_nettype none

package fpb_pkg;

   localparam int unsigned FRAME_WIDTH_DEFAULT  = 1024;
   localparam int unsigned FRAME_HEIGHT_DEFAULT = 256;

   localparam int unsigned PIXEL_W  = 8;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned WEIGHT_W = 3;
   localparam int unsigned VALUE_W  = 9;

   localparam logic OP_BLEND = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [MODE_W-1:0] MODE_ADD      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REPLACE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVERAGE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd3;

endpackage

`default_nettype wire

### rtl/fpb_frame_mem.sv
// ---------------------------------------------------------------------------
// Framebuffer pixel store
// One write port, one read port, registered read data.
// Read during write to the same entry returns the old contents.
// ---------------------------------------------------------------------------
`default_nettype none

module fpb_frame_mem #(
   parameter int unsigned DEPTH  = fpb_pkg::FRAME_WIDTH_DEFAULT * fpb_pkg::FRAME_HEIGHT_DEFAULT,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [fpb_pkg::PIXEL_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [fpb_pkg::PIXEL_W-1:0] rd_data
);

   logic [fpb_pkg::PIXEL_W-1:0] mem_ff [DEPTH];
   logic [fpb_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/fpb_blend_alu.sv
// ---------------------------------------------------------------------------
// Pixel blend arithmetic
// Mixes stored pixel and signed operand; saturates to 0..255 except REPLACE.
// ---------------------------------------------------------------------------
`default_nettype none

module fpb_blend_alu (
   input  wire logic        [fpb_pkg::PIXEL_W-1:0]  stored_pixel,
   input  wire logic        [fpb_pkg::MODE_W-1:0]   blend_mode,
   input  wire logic        [fpb_pkg::WEIGHT_W-1:0] blend_weight,
   input  wire logic signed [fpb_pkg::VALUE_W-1:0]  pixel_value,
   output logic             [fpb_pkg::PIXEL_W-1:0]  blend_pixel
);

   function automatic logic [fpb_pkg::PIXEL_W-1:0] clamp_pixel(input logic signed [13:0] s);
      logic [fpb_pkg::PIXEL_W-1:0] r;
      if (s < 0) begin
         r = '0;
      end else if (s > 14'sd255) begin
         r = '1;
      end else begin
         r = s[fpb_pkg::PIXEL_W-1:0];
      end
      return r;
   endfunction

   logic signed [13:0] p_ext;
   logic signed [13:0] v_ext;
   logic        [3:0]  inv_w;
   logic signed [13:0] wt_old;
   logic signed [13:0] wt_new;
   logic signed [13:0] add_sum;
   logic signed [13:0] mix_sum;

   assign p_ext   = {6'b0, stored_pixel};
   assign v_ext   = {{5{pixel_value[fpb_pkg::VALUE_W-1]}}, pixel_value};
   assign inv_w   = 4'd8 - {1'b0, blend_weight};
   assign wt_old  = {10'b0, inv_w};
   assign wt_new  = {11'b0, blend_weight};
   assign add_sum = p_ext + v_ext;
   assign mix_sum = (p_ext * wt_old) + (v_ext * wt_new);

   // Negative sums clamp to zero, so an arithmetic shift gives the same
   // answer as division truncating toward zero.
   always_comb begin
      unique case (blend_mode)
         fpb_pkg::MODE_ADD:      blend_pixel = clamp_pixel(add_sum);
         fpb_pkg::MODE_REPLACE:  blend_pixel = pixel_value[fpb_pkg::PIXEL_W-1:0];
         fpb_pkg::MODE_AVERAGE:  blend_pixel = clamp_pixel(add_sum >>> 1);
         fpb_pkg::MODE_WEIGHTED: blend_pixel = clamp_pixel(mix_sum >>> 3);
         default:                blend_pixel = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/framebuffer_pixel_blend_core.sv
// ---------------------------------------------------------------------------
// Framebuffer pixel blend core
// Grey 8-bit framebuffer with read-modify-write pixel blending.
// req_ channel: one pixel operation per transaction (blend or read at x,y).
// rsp_ channel: one result per transaction, the pixel after the operation,
// or zero with out_of_range set when (x,y) lies outside the frame.
// Throughput: one transaction per cycle unless the output stalls. Memory read
// data is registered on acceptance, with the request in the execute stage; the
// blend result then goes into the output register, which raises rsp_valid.
// Back-to-back hits on the same pixel are forwarded from the write stage, so
// the memory's single read and write port set the rate.
// Reset: a clearing pass writes zero to every pixel, one per cycle, over all
// FRAME_WIDTH*FRAME_HEIGHT addresses (262144 at defaults); req_ready stays low.
// Stall: when rsp_ready is low with a result pending, the pipeline freezes
// and req_ready drops in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module framebuffer_pixel_blend_core #(
   parameter int unsigned FRAME_WIDTH  = fpb_pkg::FRAME_WIDTH_DEFAULT,
   parameter int unsigned FRAME_HEIGHT = fpb_pkg::FRAME_HEIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic        [fpb_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic        [fpb_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic        [fpb_pkg::MODE_W-1:0]   req_blend_mode,
   input  wire logic        [fpb_pkg::WEIGHT_W-1:0] req_blend_weight,
   input  wire logic signed [fpb_pkg::VALUE_W-1:0]  req_pixel_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic             [fpb_pkg::PIXEL_W-1:0]  rsp_result_pixel,
   output logic                                    rsp_out_of_range
);

   `include "framebuffer_pixel_blend_core_defines.svh"

   localparam int unsigned DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   // clearing pass
   logic              clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // execute stage
   logic                               s2_valid_ff, s2_valid_in;
   logic                               s2_op_ff;
   logic                               s2_oor_ff;
   logic        [fpb_pkg::MODE_W-1:0]   s2_mode_ff;
   logic        [fpb_pkg::WEIGHT_W-1:0] s2_weight_ff;
   logic signed [fpb_pkg::VALUE_W-1:0]  s2_value_ff;
   logic        [ADDR_W-1:0]           s2_addr_ff;
   logic                               s2_fwd_hit_ff, s2_fwd_hit_in;
   logic        [fpb_pkg::PIXEL_W-1:0]  s2_fwd_data_ff;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [fpb_pkg::PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                        rsp_oor_ff;

   logic                        advance;
   logic                        accept;
   logic [ADDR_W-1:0]           req_addr;
   logic                        req_in_range;
   logic [fpb_pkg::PIXEL_W-1:0] mem_rd_data;
   logic [fpb_pkg::PIXEL_W-1:0] stored_pixel;
   logic [fpb_pkg::PIXEL_W-1:0] blend_pixel;
   logic                        s2_write;
   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [fpb_pkg::PIXEL_W-1:0] mem_wr_data;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !clr_active_ff;
   assign accept    = req_valid && req_ready;

   assign req_in_range = (32'(req_pos_x) < FRAME_WIDTH) && (32'(req_pos_y) < FRAME_HEIGHT);
   assign req_addr     = ADDR_W'((32'(req_pos_y) * FRAME_WIDTH) + 32'(req_pos_x));

   assign s2_write = s2_valid_ff && !s2_oor_ff && (s2_op_ff == fpb_pkg::OP_BLEND);

   // Memory returns old data when read and written together: take the
   // value the execute stage is writing this cycle instead.
   assign s2_fwd_hit_in = accept && s2_write && (s2_addr_ff == req_addr);
   assign stored_pixel  = s2_fwd_hit_ff ? s2_fwd_data_ff : mem_rd_data;

   assign mem_wr_en   = clr_active_ff || (advance && s2_write);
   assign mem_wr_addr = clr_active_ff ? clr_addr_ff : s2_addr_ff;
   assign mem_wr_data = clr_active_ff ? '0 : blend_pixel;

   fpb_frame_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (mem_rd_data)
   );

   fpb_blend_alu u_blend_alu (
      .stored_pixel (stored_pixel),
      .blend_mode   (s2_mode_ff),
      .blend_weight (s2_weight_ff),
      .pixel_value  (s2_value_ff),
      .blend_pixel  (blend_pixel)
   );

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         s2_valid_in  = accept;
         rsp_valid_in = s2_valid_ff;
      end
   end

   always_comb begin
      if (s2_oor_ff) begin
         rsp_pixel_in = '0;
      end else if (s2_op_ff == fpb_pkg::OP_READ) begin
         rsp_pixel_in = stored_pixel;
      end else begin
         rsp_pixel_in = blend_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_fwd_hit_ff <= 1'b0;
      end else if (advance) begin
         s2_fwd_hit_ff <= s2_fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_op_ff       <= req_opcode;
         s2_oor_ff      <= !req_in_range;
         s2_mode_ff     <= req_blend_mode;
         s2_weight_ff   <= req_blend_weight;
         s2_value_ff    <= req_pixel_value;
         s2_addr_ff     <= req_addr;
         s2_fwd_data_ff <= blend_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_oor_ff   <= s2_oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pixel_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   `FPB_ASSERT_SAME(a_oor_zero, clock, reset,
      rsp_valid && rsp_out_of_range, rsp_result_pixel == '0,
      "out-of-range result carries a nonzero pixel")
   `FPB_ASSERT_SAME(a_clear_idle, clock, reset,
      clr_active_ff, !s2_valid_ff && !rsp_valid_ff,
      "transaction in flight during clearing pass")
   `FPB_ASSERT_SAME(a_fwd_valid, clock, reset,
      s2_fwd_hit_ff, s2_valid_ff,
      "forwarding hit without a transaction in execute")
   `FPB_ASSERT_NEXT(a_accept_exec, clock, reset,
      accept, s2_valid_ff,
      "accepted transaction did not reach execute")

endmodule

`default_nettype wire
